// ===== sv/lcsc_pkg.sv =====
// Shared types, constants and the palette table of the LCD capture scan converter.
`timescale 1ns / 1ps
`default_nettype none

package lcsc_pkg;

    // Default geometry.
    localparam int SOURCE_WIDTH     = 160;
    localparam int SOURCE_HEIGHT    = 144;
    localparam int OUTPUT_WIDTH     = 800;
    localparam int OUTPUT_LINES     = 150;
    localparam int SAMPLES_PER_WORD = 8;

    // Fixed field widths.
    localparam int WORD_W      = 32;
    localparam int COLOR_W     = 16;
    localparam int BANK_W      = 3;
    localparam int LEFT_W      = 9;
    localparam int CFG_INDEX_W = 2;

    localparam int BLANK_LINES   = 3;
    localparam int PALETTE_BANKS = 5;

    // Word queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Reset values.
    localparam logic [BANK_W-1:0]  PALETTE_SELECT_RESET   = 3'd1;
    localparam logic [COLOR_W-1:0] BACKGROUND_COLOR_RESET = 16'h0000;
    localparam logic [LEFT_W-1:0]  LEFT_BORDER_RESET      = 9'd40;
    localparam int                 DISPLAY_LINE_RESET     = 2;

    typedef enum logic {
        OP_CAPTURE = 1'b0,
        OP_DISPLAY = 1'b1
    } op_e_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PALETTE_SELECT   = 2'd0,
        CFG_BACKGROUND_COLOR = 2'd1,
        CFG_LEFT_BORDER      = 2'd2
    } cfg_index_t;

    typedef struct packed {
        op_e_t             op;
        logic [WORD_W-1:0] word;
    } item_t;

    typedef struct packed {
        logic [BANK_W-1:0]  palette_select;
        logic [COLOR_W-1:0] background_color;
        logic [LEFT_W-1:0]  left_border;
    } cfg_t;

    // A display pixel on its way from the store read to the output register.
    typedef struct packed {
        logic       use_bg;
        logic       line_last;
        logic       frame_last;
        logic [1:0] shade;
    } pixel_t;

    // Palette banks in RGB888, four shades per bank.
    localparam logic [23:0] PALETTE_RGB [PALETTE_BANKS*4] = '{
        24'hC0D635, 24'h869625, 24'h4D5615, 24'h131505,
        24'hC6DE8C, 24'h39613A, 24'h84A563, 24'h081711,
        24'hFFD895, 24'hFDBF68, 24'hFB8A9C, 24'h776DBD,
        24'hB5C69C, 24'h8D9C7B, 24'h637251, 24'h303820,
        24'hEFECDA, 24'hD9BE72, 24'hA32135, 24'h231916
    };

    // Bank values past the last bank use the last bank.
    function automatic logic [COLOR_W-1:0] palette_color(
        input logic [BANK_W-1:0] bank,
        input logic [1:0]        shade
    );
        logic [BANK_W-1:0] bank_sat;
        logic [23:0]       rgb;
        bank_sat = (bank >= BANK_W'(PALETTE_BANKS)) ? BANK_W'(PALETTE_BANKS - 1) : bank;
        rgb      = PALETTE_RGB[{bank_sat, shade}];
        return {rgb[23:19], rgb[15:10], rgb[7:3]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/lcd_capture_scan_converter.sv =====
// Top level of the LCD capture scan converter: configuration registers and part wiring.
//
//   channel   dir   handshake            content
//   s_        in    s_valid / s_ready    s_operation, s_capture_word
//   m_        out   m_valid / m_ready    m_pixel_color, m_line_last, m_frame_last
//   cfg_      in    cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// A display word yields one pixel word; one per cycle unless captures or m_ready low hold it.
// A capture word holds the back end for its SAMPLES_PER_WORD samples, one store write each.
// After reset the store is cleared, one entry a cycle, all SOURCE_WIDTH * SOURCE_HEIGHT entries
// (23040 by default); s_ready stays low until then while configuration writes are taken.
// A four-word queue sits between input and back end; the output register holds on m_ready low.
`timescale 1ns / 1ps
`default_nettype none

module lcd_capture_scan_converter #(
    parameter int SOURCE_WIDTH     = lcsc_pkg::SOURCE_WIDTH,
    parameter int SOURCE_HEIGHT    = lcsc_pkg::SOURCE_HEIGHT,
    parameter int OUTPUT_WIDTH     = lcsc_pkg::OUTPUT_WIDTH,
    parameter int OUTPUT_LINES     = lcsc_pkg::OUTPUT_LINES,
    parameter int SAMPLES_PER_WORD = lcsc_pkg::SAMPLES_PER_WORD
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_operation,
    input  wire logic [lcsc_pkg::WORD_W-1:0]       s_capture_word,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [lcsc_pkg::COLOR_W-1:0]           m_pixel_color,
    output logic                                   m_line_last,
    output logic                                   m_frame_last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lcsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [lcsc_pkg::COLOR_W-1:0]      cfg_data
);

    lcsc_pkg::cfg_t   cfg_reg;
    logic             clearing;
    logic             q_valid;
    logic             q_pop;
    lcsc_pkg::item_t  q_item;
    logic             b_valid;
    logic             b_ready;
    lcsc_pkg::pixel_t b_pix;

    assign cfg_ready = 1'b1;

    // Writes to an index past the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.palette_select   <= lcsc_pkg::PALETTE_SELECT_RESET;
            cfg_reg.background_color <= lcsc_pkg::BACKGROUND_COLOR_RESET;
            cfg_reg.left_border      <= lcsc_pkg::LEFT_BORDER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (lcsc_pkg::cfg_index_t'(cfg_index))
                lcsc_pkg::CFG_PALETTE_SELECT: begin
                    cfg_reg.palette_select <= cfg_data[lcsc_pkg::BANK_W-1:0];
                end
                lcsc_pkg::CFG_BACKGROUND_COLOR: begin
                    cfg_reg.background_color <= cfg_data;
                end
                lcsc_pkg::CFG_LEFT_BORDER: begin
                    cfg_reg.left_border <= cfg_data[lcsc_pkg::LEFT_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    lcsc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_capture_word (s_capture_word),
        .clearing       (clearing),
        .q_pop          (q_pop),
        .q_valid        (q_valid),
        .q_item         (q_item)
    );

    lcsc_back #(
        .SOURCE_WIDTH     (SOURCE_WIDTH),
        .SOURCE_HEIGHT    (SOURCE_HEIGHT),
        .OUTPUT_WIDTH     (OUTPUT_WIDTH),
        .OUTPUT_LINES     (OUTPUT_LINES),
        .SAMPLES_PER_WORD (SAMPLES_PER_WORD)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .left_border (cfg_reg.left_border),
        .b_valid     (b_valid),
        .b_pix       (b_pix),
        .b_ready     (b_ready)
    );

    lcsc_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .b_valid       (b_valid),
        .b_pix         (b_pix),
        .b_ready       (b_ready),
        .cfg           (cfg_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_color (m_pixel_color),
        .m_line_last   (m_line_last),
        .m_frame_last  (m_frame_last)
    );

endmodule

`default_nettype wire

// ===== sv/lcsc_front.sv =====
// Front part: accepts input words and queues them, tagged by operation, for the back part.
`timescale 1ns / 1ps
`default_nettype none

module lcsc_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_operation,
    input  wire logic [lcsc_pkg::WORD_W-1:0]   s_capture_word,
    input  wire logic                          clearing,
    input  wire logic                          q_pop,
    output logic                               q_valid,
    output lcsc_pkg::item_t                    q_item
);

    lcsc_pkg::item_t                  queue_reg [lcsc_pkg::QUEUE_DEPTH];
    logic [lcsc_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [lcsc_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [lcsc_pkg::QPTR_W:0]        count_reg, count_next;
    logic                             push;
    logic                             pop;

    // No word is taken while the store is being cleared.
    assign s_ready = !clearing && (count_reg != (lcsc_pkg::QPTR_W+1)'(lcsc_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == lcsc_pkg::QPTR_W'(lcsc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == lcsc_pkg::QPTR_W'(lcsc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= '{op: lcsc_pkg::op_e_t'(s_operation), word: s_capture_word};
        end
    end

endmodule

`default_nettype wire

// ===== sv/lcsc_back.sv =====
// Back part: frame store, capture writer, display raster counters and store read stage.
`timescale 1ns / 1ps
`default_nettype none

module lcsc_back #(
    parameter int SOURCE_WIDTH     = lcsc_pkg::SOURCE_WIDTH,
    parameter int SOURCE_HEIGHT    = lcsc_pkg::SOURCE_HEIGHT,
    parameter int OUTPUT_WIDTH     = lcsc_pkg::OUTPUT_WIDTH,
    parameter int OUTPUT_LINES     = lcsc_pkg::OUTPUT_LINES,
    parameter int SAMPLES_PER_WORD = lcsc_pkg::SAMPLES_PER_WORD
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_valid,
    input  wire lcsc_pkg::item_t                 q_item,
    output logic                                 q_pop,
    output logic                                 clearing,
    input  wire logic [lcsc_pkg::LEFT_W-1:0]     left_border,
    output logic                                 b_valid,
    output lcsc_pkg::pixel_t                     b_pix,
    input  wire logic                            b_ready
);

    localparam int COL_W   = $clog2(SOURCE_WIDTH);
    localparam int ROW_W   = $clog2(SOURCE_HEIGHT);
    localparam int DEPTH   = SOURCE_WIDTH * SOURCE_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DCOL_W  = $clog2(OUTPUT_WIDTH);
    localparam int LINE_W  = $clog2(OUTPUT_LINES);
    localparam int SAMP_W  = (SAMPLES_PER_WORD > 1) ? $clog2(SAMPLES_PER_WORD) : 1;
    localparam int RCMP_W  = ((LINE_W > ROW_W) ? LINE_W : ROW_W) + 1;
    localparam int OFF_W   = ((DCOL_W > lcsc_pkg::LEFT_W) ? DCOL_W : lcsc_pkg::LEFT_W) + 1;

    logic [1:0] store_mem [DEPTH];

    // Clearing pass after reset.
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Capture position.
    logic [SAMP_W-1:0] samp_reg, samp_next;
    logic [COL_W-1:0]  cap_col_reg, cap_col_next;
    logic [ROW_W-1:0]  cap_row_reg, cap_row_next;

    // Display raster position.
    logic [DCOL_W-1:0] disp_col_reg, disp_col_next;
    logic [LINE_W-1:0] disp_line_reg, disp_line_next;

    // Read stage.
    logic              b_valid_reg, b_valid_next;
    logic              b_use_bg_reg, b_line_last_reg, b_frame_last_reg;
    logic [1:0]        rd_data_reg;

    logic              cap_fire, disp_fire, samp_last;
    logic [4:0]        nib_lsb;
    logic [3:0]        nib;
    logic [ROW_W-1:0]  row_step;
    logic [ADDR_W-1:0] cap_addr;
    logic [LINE_W-1:0] src_row;
    logic [OFF_W-1:0]  col_off;
    logic [COL_W-1:0]  src_col;
    logic [ADDR_W-1:0] rd_addr;
    logic              use_bg, line_last, frame_last;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [1:0]        wr_data;

    assign clearing  = clr_busy_reg;
    assign samp_last = (samp_reg == SAMP_W'(SAMPLES_PER_WORD - 1));
    assign cap_fire  = q_valid && (q_item.op == lcsc_pkg::OP_CAPTURE) && !clr_busy_reg;
    assign disp_fire = q_valid && (q_item.op == lcsc_pkg::OP_DISPLAY) && !clr_busy_reg
                       && (!b_valid_reg || b_ready);
    // A capture word leaves the queue with its last sample.
    assign q_pop     = (cap_fire && samp_last) || disp_fire;

    // One capture sample per cycle.
    always_comb begin
        nib_lsb   = 5'({samp_reg, 2'b00});
        nib       = q_item.word[nib_lsb +: 4];
        row_step  = (cap_row_reg == ROW_W'(SOURCE_HEIGHT - 1)) ? '0 : cap_row_reg + 1'b1;
        samp_next = samp_reg;
        if (nib[2]) begin
            cap_row_next = '0;
        end else if (nib[3]) begin
            cap_row_next = row_step;
        end else begin
            cap_row_next = cap_row_reg;
        end
        if (nib[3]) begin
            cap_col_next = '0;
        end else begin
            cap_col_next = (cap_col_reg == COL_W'(SOURCE_WIDTH - 1)) ? '0 : cap_col_reg + 1'b1;
        end
        cap_addr = ADDR_W'(ADDR_W'(cap_row_next) * ADDR_W'(SOURCE_WIDTH))
                   + ADDR_W'(cap_col_next);
        if (cap_fire) begin
            samp_next = samp_last ? '0 : samp_reg + 1'b1;
        end
    end

    // Display pixel classification and raster advance.
    always_comb begin
        src_row    = disp_line_reg - LINE_W'(lcsc_pkg::BLANK_LINES);
        col_off    = OFF_W'(disp_col_reg) - OFF_W'(left_border);
        src_col    = col_off[COL_W:1];
        use_bg     = (disp_line_reg < LINE_W'(lcsc_pkg::BLANK_LINES))
                     || (disp_line_reg >= LINE_W'(OUTPUT_LINES - lcsc_pkg::BLANK_LINES))
                     || (RCMP_W'(src_row) >= RCMP_W'(SOURCE_HEIGHT))
                     || (OFF_W'(disp_col_reg) < OFF_W'(left_border))
                     || (col_off >= OFF_W'(2 * SOURCE_WIDTH));
        rd_addr    = ADDR_W'(ADDR_W'(src_row) * ADDR_W'(SOURCE_WIDTH)) + ADDR_W'(src_col);
        line_last  = (disp_col_reg >= DCOL_W'(OUTPUT_WIDTH - 1));
        frame_last = line_last && (disp_line_reg >= LINE_W'(OUTPUT_LINES - 1));
        disp_col_next  = disp_col_reg;
        disp_line_next = disp_line_reg;
        if (disp_fire) begin
            if (line_last) begin
                disp_col_next  = '0;
                disp_line_next = (disp_line_reg == LINE_W'(OUTPUT_LINES - 1))
                                 ? '0 : disp_line_reg + 1'b1;
            end else begin
                disp_col_next = disp_col_reg + 1'b1;
            end
        end
        priority if (disp_fire) begin
            b_valid_next = 1'b1;
        end else if (b_ready) begin
            b_valid_next = 1'b0;
        end else begin
            b_valid_next = b_valid_reg;
        end
    end

    always_comb begin
        wr_en   = clr_busy_reg || cap_fire;
        wr_addr = clr_busy_reg ? clr_addr_reg : cap_addr;
        wr_data = clr_busy_reg ? 2'b00 : nib[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            samp_reg      <= '0;
            cap_col_reg   <= '0;
            cap_row_reg   <= '0;
            disp_col_reg  <= '0;
            disp_line_reg <= LINE_W'(lcsc_pkg::DISPLAY_LINE_RESET);
            b_valid_reg   <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            samp_reg      <= samp_next;
            if (cap_fire) begin
                cap_col_reg <= cap_col_next;
                cap_row_reg <= cap_row_next;
            end
            disp_col_reg  <= disp_col_next;
            disp_line_reg <= disp_line_next;
            b_valid_reg   <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // Read data only moves when a new pixel is issued, so it holds while stalled.
    always_ff @(posedge aclk) begin
        if (disp_fire && !use_bg) begin
            rd_data_reg <= store_mem[rd_addr];
        end
        if (disp_fire) begin
            b_use_bg_reg     <= use_bg;
            b_line_last_reg  <= line_last;
            b_frame_last_reg <= frame_last;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_pix   = '{use_bg:     b_use_bg_reg,
                       line_last:  b_line_last_reg,
                       frame_last: b_frame_last_reg,
                       shade:      rd_data_reg};

endmodule

`default_nettype wire

// ===== sv/lcsc_out.sv =====
// Output stage: palette-maps shades or takes the background, holds the word for the sink.
`timescale 1ns / 1ps
`default_nettype none

module lcsc_out (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           b_valid,
    input  wire lcsc_pkg::pixel_t               b_pix,
    output logic                                b_ready,
    input  wire lcsc_pkg::cfg_t                 cfg,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [lcsc_pkg::COLOR_W-1:0]        m_pixel_color,
    output logic                                m_line_last,
    output logic                                m_frame_last
);

    logic                           m_valid_reg;
    logic [lcsc_pkg::COLOR_W-1:0]   color_reg, color_next;
    logic                           line_last_reg;
    logic                           frame_last_reg;

    assign b_ready = !m_valid_reg || m_ready;

    always_comb begin
        color_next = b_pix.use_bg ? cfg.background_color
                                  : lcsc_pkg::palette_color(cfg.palette_select, b_pix.shade);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_ready) begin
            m_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid && b_ready) begin
            color_reg      <= color_next;
            line_last_reg  <= b_pix.line_last;
            frame_last_reg <= b_pix.frame_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_color = color_reg;
    assign m_line_last   = line_last_reg;
    assign m_frame_last  = frame_last_reg;

endmodule

`default_nettype wire

// ===== sv/lcsc_checker.sv =====
// Port-level checker of the LCD capture scan converter and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lcsc_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire logic                              s_operation,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic [lcsc_pkg::COLOR_W-1:0]      m_pixel_color,
    input  wire logic                              m_line_last,
    input  wire logic                              m_frame_last
);

    // Display words taken whose pixel word has not yet been delivered.
    logic [7:0] pend_reg;
    logic       disp_in;
    logic       pix_out;

    assign disp_in = s_valid && s_ready && s_operation;
    assign pix_out = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (disp_in && !pix_out) begin
            pend_reg <= pend_reg + 1'b1;
        end else if (pix_out && !disp_in) begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_ready)
        else $error("input taken while the frame store is still being cleared");

    a_frame_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_last) |-> m_line_last)
        else $error("frame end flagged on a pixel that does not end its line");

    a_no_spurious_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pend_reg != 8'd0))
        else $error("pixel word shown with no display word outstanding");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_color)
                                   && $stable(m_line_last) && $stable(m_frame_last)))
        else $error("pixel word changed while stalled");

endmodule

bind lcd_capture_scan_converter lcsc_checker u_lcsc_checker (.*);

`default_nettype wire

// ===== test/lcsc_scan_checker.sv =====
// Checker for the LCD capture scan converter: tracks the capture store and the raster, checks pixels.
`timescale 1ns / 1ps

module lcsc_scan_checker (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    input  logic                                       s_ready,
    input  logic                                       s_operation,
    input  logic [lcsc_pkg::WORD_W-1:0]                s_capture_word,
    input  logic                                       m_valid,
    input  logic                                       m_ready,
    input  logic [lcsc_pkg::COLOR_W-1:0]               m_pixel_color,
    input  logic                                       m_line_last,
    input  logic                                       m_frame_last,
    input  logic                                       cfg_valid,
    input  logic                                       cfg_ready,
    input  logic [lcsc_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  logic [lcsc_pkg::COLOR_W-1:0]               cfg_data,
    output int                                         mismatches,
    output int                                         outstanding,
    output int                                         pixels_seen,
    output int                                         captures_seen,
    output int                                         frames_seen
);

    localparam int STORE_DEPTH = lcsc_pkg::SOURCE_WIDTH * lcsc_pkg::SOURCE_HEIGHT;
    localparam int IMAGE_W     = 2 * lcsc_pkg::SOURCE_WIDTH;

    // Four shades per bank, in RGB888.
    localparam logic [23:0] BANK_RGB [0:19] = '{
        24'hC0D635, 24'h869625, 24'h4D5615, 24'h131505,
        24'hC6DE8C, 24'h39613A, 24'h84A563, 24'h081711,
        24'hFFD895, 24'hFDBF68, 24'hFB8A9C, 24'h776DBD,
        24'hB5C69C, 24'h8D9C7B, 24'h637251, 24'h303820,
        24'hEFECDA, 24'hD9BE72, 24'hA32135, 24'h231916
    };

    typedef struct packed {
        logic [lcsc_pkg::COLOR_W-1:0] color;
        logic                         line_last;
        logic                         frame_last;
    } pixel_word_t;

    pixel_word_t due_pixels [$];
    logic [1:0]  shade_store [0:STORE_DEPTH-1];

    int cap_col;
    int cap_row;
    int scan_col;
    int scan_line;
    int n_bad;
    int n_pixels;
    int n_captures;
    int n_frames;

    logic [lcsc_pkg::BANK_W-1:0]  bank_sel;
    logic [lcsc_pkg::COLOR_W-1:0] border_color;
    logic [lcsc_pkg::LEFT_W-1:0]  image_left;

    function automatic logic [lcsc_pkg::COLOR_W-1:0] rgb888_to_565(input logic [23:0] rgb);
        logic [4:0] red;
        logic [5:0] green;
        logic [4:0] blue;
        red   = rgb[23:19];
        green = rgb[15:10];
        blue  = rgb[7:3];
        return {red, green, blue};
    endfunction

    task automatic store_sample(input logic [3:0] nib);
        if (nib[2]) begin
            cap_row = 0;
        end
        if (nib[3]) begin
            cap_col = 0;
            if (!nib[2]) begin
                cap_row = (cap_row + 1) % lcsc_pkg::SOURCE_HEIGHT;
            end
        end else begin
            cap_col = (cap_col + 1) % lcsc_pkg::SOURCE_WIDTH;
        end
        shade_store[cap_row * lcsc_pkg::SOURCE_WIDTH + cap_col] = nib[1:0];
    endtask

    // Produces the pixel at the current raster position, then steps the raster.
    task automatic scan_pixel(output pixel_word_t px);
        int   row;
        int   off;
        int   bank;
        logic at_line_end;
        px.color = border_color;
        row = scan_line - lcsc_pkg::BLANK_LINES;
        off = scan_col - int'(image_left);
        if (scan_line >= lcsc_pkg::BLANK_LINES &&
            scan_line < lcsc_pkg::OUTPUT_LINES - lcsc_pkg::BLANK_LINES &&
            row < lcsc_pkg::SOURCE_HEIGHT && off >= 0 && off < IMAGE_W) begin
            bank = (int'(bank_sel) >= lcsc_pkg::PALETTE_BANKS)
                   ? lcsc_pkg::PALETTE_BANKS - 1 : int'(bank_sel);
            px.color = rgb888_to_565(BANK_RGB[bank * 4
                       + int'(shade_store[row * lcsc_pkg::SOURCE_WIDTH + off / 2])]);
        end
        at_line_end   = (scan_col >= lcsc_pkg::OUTPUT_WIDTH - 1);
        px.line_last  = at_line_end;
        px.frame_last = at_line_end && (scan_line >= lcsc_pkg::OUTPUT_LINES - 1);
        if (at_line_end) begin
            scan_col  = 0;
            scan_line = (scan_line + 1) % lcsc_pkg::OUTPUT_LINES;
        end else begin
            scan_col++;
        end
    endtask

    task automatic flag_mismatch(input string what, input pixel_word_t want,
                                 input pixel_word_t got);
        n_bad++;
        if (n_bad <= 10) begin
            $display("%0t: %s: expected color %h line_last %b frame_last %b, got %h %b %b",
                     $time, what, want.color, want.line_last, want.frame_last,
                     got.color, got.line_last, got.frame_last);
        end
    endtask

    always @(posedge aclk) begin : watch
        pixel_word_t want;
        pixel_word_t got;
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                shade_store[i] = 2'b00;
            end
            due_pixels.delete();
            cap_col      = 0;
            cap_row      = 0;
            scan_col     = 0;
            scan_line    = lcsc_pkg::DISPLAY_LINE_RESET;
            bank_sel     = lcsc_pkg::PALETTE_SELECT_RESET;
            border_color = lcsc_pkg::BACKGROUND_COLOR_RESET;
            image_left   = lcsc_pkg::LEFT_BORDER_RESET;
            n_bad        = 0;
            n_pixels     = 0;
            n_captures   = 0;
            n_frames     = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lcsc_pkg::CFG_PALETTE_SELECT:
                        bank_sel = cfg_data[lcsc_pkg::BANK_W-1:0];
                    lcsc_pkg::CFG_BACKGROUND_COLOR:
                        border_color = cfg_data;
                    lcsc_pkg::CFG_LEFT_BORDER:
                        image_left = cfg_data[lcsc_pkg::LEFT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_operation == lcsc_pkg::OP_CAPTURE) begin
                    for (int k = 0; k < lcsc_pkg::SAMPLES_PER_WORD; k++) begin
                        store_sample(s_capture_word[4 * k +: 4]);
                    end
                    n_captures++;
                end else begin
                    scan_pixel(want);
                    due_pixels.push_back(want);
                end
            end
            if (m_valid && m_ready) begin
                got = {m_pixel_color, m_line_last, m_frame_last};
                if (due_pixels.size() == 0) begin
                    flag_mismatch("pixel word with nothing expected", '0, got);
                end else begin
                    want = due_pixels.pop_front();
                    if (want !== got) begin
                        flag_mismatch("pixel word differs", want, got);
                    end
                end
                n_pixels++;
                if (got.frame_last) begin
                    n_frames++;
                end
            end
        end
        mismatches    <= n_bad;
        outstanding   <= due_pixels.size();
        pixels_seen   <= n_pixels;
        captures_seen <= n_captures;
        frames_seen   <= n_frames;
    end

endmodule

// ===== test/testbench.sv =====
// Top of the LCD capture scan converter test: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int                               N_SETTINGS   = 8;
    localparam int                               RANDOM_ITEMS = 900;
    localparam int                               SWEEP_PIXELS = 120;
    localparam int                               SETTLE       = 64;
    localparam logic [lcsc_pkg::CFG_INDEX_W-1:0] CFG_SPARE    = 2'd3;

    logic                             aclk           = 1'b0;
    logic                             aresetn        = 1'b0;
    logic                             s_valid        = 1'b0;
    logic                             s_ready;
    logic                             s_operation    = lcsc_pkg::OP_CAPTURE;
    logic [lcsc_pkg::WORD_W-1:0]      s_capture_word = '0;
    logic                             m_valid;
    logic                             m_ready        = 1'b0;
    logic [lcsc_pkg::COLOR_W-1:0]     m_pixel_color;
    logic                             m_line_last;
    logic                             m_frame_last;
    logic                             cfg_valid      = 1'b0;
    logic                             cfg_ready;
    logic [lcsc_pkg::CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [lcsc_pkg::COLOR_W-1:0]     cfg_data       = '0;

    int mismatches;
    int outstanding;
    int pixels_seen;
    int captures_seen;
    int frames_seen;

    // While set, neither side inserts idle cycles.
    bit fast_mode = 1'b0;

    // Register plans; banks 5 to 7 saturate, borders 481 and 511 cut the image off.
    logic [lcsc_pkg::BANK_W-1:0] bank_plan [N_SETTINGS] =
        '{3'd0, 3'd4, 3'd7, 3'd5, 3'd6, 3'd2, 3'd3, 3'd1};
    logic [lcsc_pkg::LEFT_W-1:0] left_plan [N_SETTINGS] =
        '{9'd0, 9'd480, 9'd511, 9'd40, 9'd1, 9'd320, 9'd481, 9'd255};

    lcd_capture_scan_converter DUT (.*);

    lcsc_scan_checker pixel_check (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic put_item(input lcsc_pkg::op_e_t op,
                            input logic [lcsc_pkg::WORD_W-1:0] word);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_capture_word <= word;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Keeps cfg_valid as the caller left it; only index and data change here.
    task automatic cfg_beat(input logic [lcsc_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [lcsc_pkg::COLOR_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_regs(input logic [lcsc_pkg::BANK_W-1:0] bank,
                              input logic [lcsc_pkg::COLOR_W-1:0] bg,
                              input logic [lcsc_pkg::LEFT_W-1:0] left);
        logic [lcsc_pkg::COLOR_W-1:0] junk;
        junk = lcsc_pkg::COLOR_W'($urandom);
        cfg_valid <= 1'b1;
        cfg_beat(lcsc_pkg::CFG_PALETTE_SELECT,
                 {junk[lcsc_pkg::COLOR_W-1:lcsc_pkg::BANK_W], bank});
        cfg_beat(lcsc_pkg::CFG_BACKGROUND_COLOR, bg);
        cfg_beat(lcsc_pkg::CFG_LEFT_BORDER,
                 {junk[lcsc_pkg::COLOR_W-1:lcsc_pkg::LEFT_W], left});
        // The spare index must leave every register alone.
        cfg_beat(CFG_SPARE, ~junk);
        cfg_valid <= 1'b0;
    endtask

    // Drain: every pixel word back, then time for queued capture words to retire.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin : sink
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = fast_mode ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : source
        int                           random_sent;
        int                           pick;
        int                           len;
        logic [lcsc_pkg::WORD_W-1:0]  word;
        logic [lcsc_pkg::COLOR_W-1:0] bg;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // The store clear is still running here; register writes are taken meanwhile.
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_beat(CFG_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;

        // Directed words under reset settings.
        put_item(lcsc_pkg::OP_DISPLAY, 32'h0000_0000);
        put_item(lcsc_pkg::OP_CAPTURE, 32'h0000_0000);
        put_item(lcsc_pkg::OP_CAPTURE, 32'hFFFF_FFFF);
        put_item(lcsc_pkg::OP_CAPTURE, 32'h4444_4444);
        put_item(lcsc_pkg::OP_CAPTURE, 32'h3333_3333);
        put_item(lcsc_pkg::OP_CAPTURE, 32'h2B1A_C937);
        put_item(lcsc_pkg::OP_DISPLAY, 32'hFFFF_FFFF);
        // 144 hsyncs without vsync bring the row all the way around.
        repeat (18) put_item(lcsc_pkg::OP_CAPTURE, 32'h8888_8888);
        put_item(lcsc_pkg::OP_DISPLAY, 32'h5A5A_A5A5);

        random_sent = 0;
        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            drain();
            bg = (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF : 16'($urandom);
            write_regs(bank_plan[ph], bg, left_plan[ph]);

            while (random_sent < (ph + 1) * RANDOM_ITEMS / N_SETTINGS) begin
                pick      = $urandom_range(0, 99);
                fast_mode = ($urandom_range(0, 7) == 0);
                if (pick < 55) begin
                    // One source line: hsync on the first sample, then plain pixels.
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 24) : 20;
                    for (int w = 0; w < len; w++) begin
                        word = $urandom & 32'h3333_3333;
                        if (w == 0) begin
                            word[3] = 1'b1;
                            word[2] = ($urandom_range(0, 11) == 0);
                        end
                        put_item(lcsc_pkg::OP_CAPTURE, word);
                    end
                    random_sent += len;
                end else if (pick < 80) begin
                    len = $urandom_range(1, 40);
                    repeat (len) put_item(lcsc_pkg::OP_DISPLAY, $urandom);
                    random_sent += len;
                end else if (pick < 92) begin
                    put_item(lcsc_pkg::OP_CAPTURE, $urandom);
                    random_sent++;
                end else begin
                    put_item(lcsc_pkg::OP_CAPTURE, $urandom | 32'h8888_8888);
                    random_sent++;
                end
            end

            // A run of display words at full rate moves the raster along.
            fast_mode = 1'b1;
            repeat (SWEEP_PIXELS) put_item(lcsc_pkg::OP_DISPLAY, $urandom);
            fast_mode = 1'b0;
        end

        drain();
        $display("Checked %0d pixel words, %0d of them ending a frame, and %0d capture words.",
                 pixels_seen, frames_seen, captures_seen);
        $display("Register settings used: reset plus %0d; %0d mismatches, %0d words missing.",
                 N_SETTINGS, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Timeout with %0d pixel words still expected.", outstanding);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
